@@ hdl/bhm_pkg.sv @@
package bhm_pkg;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int SIZE_W   = 9;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 11;
    localparam int FILL_W   = 3;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_QUERY3 = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_QUERY     = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  live_count;
        logic [FILL_W-1:0]   max_fill;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_FILL,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_UPD,
        S_DONE
    } t_state;

endpackage

@@ hdl/bucketed_hash_map_engine_top.sv @@
// bucketed hash map: 32-bit keys map to 32-bit values. the bucket is key mod table_size
// (table_size is clamped to 1..NUM_BUCKETS), and each bucket holds up to WAYS entries packed
// from slot 0. one request is taken at a time and the input stays stalled while it runs.
// the finished result waits in an output register, so the next request can be taken while
// that result is still stalled. a request runs through a bit-serial restoring remainder over
// the key bits, most significant first, a step to fetch the bucket fill, and then a walk of
// the bucket's ways through the key/value memories (one write port, one read port), a read
// and a compare per way. a delete that hits then shifts the later entries down one slot.
// the result is offered in the same cycle that the block can take the next input transfer.
// if the previous result is still held by the output stall, the finish step waits for it.
// live_count and max_fill are kept in registers; max_fill comes from per-level bucket
// counters. no clearing pass is needed: level counters reset, and each bucket fill is
// qualified by a per-bucket valid bit that reset clears.
module bucketed_hash_map_engine_top
    import bhm_pkg::*;
#(
    parameter int NUM_BUCKETS = 256,
    parameter int WAYS        = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data
);

    localparam int BW  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FW  = $clog2(WAYS + 1);
    localparam int SW  = BW + WW;
    localparam int LCW = $clog2(NUM_BUCKETS + 1);
    localparam int RW  = BW + 1;  // remainder width, holds up to NUM_BUCKETS

    t_state r_state, n_state;

    // configuration
    logic [SIZE_W-1:0] r_table_size;

    // request
    t_in_item r_req;

    // remainder unit
    logic [RW:0]       r_rem;
    logic [5:0]        r_bitcnt;
    logic [RW-1:0]     r_mod;
    logic [RW:0]       w_rem_sh;
    logic [RW-1:0]     w_mod;

    // bucket walk
    logic [BW-1:0]     r_bucket;
    logic [FW-1:0]     r_fill;
    logic [FW-1:0]     r_way;
    logic              r_found;
    logic [FW-1:0]     r_hit;

    // stores
    logic [KEY_W-1:0]  key_mem [NUM_BUCKETS*WAYS];
    logic [VAL_W-1:0]  val_mem [NUM_BUCKETS*WAYS];
    logic [FW-1:0]     fill_mem [NUM_BUCKETS];
    logic [KEY_W-1:0]  r_rd_key;
    logic [VAL_W-1:0]  r_rd_val;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr, mem_raddr;
    logic [KEY_W-1:0]  mem_wkey;
    logic [VAL_W-1:0]  mem_wval;
    logic              key_we;

    logic [LCW-1:0]    r_level [WAYS];
    logic [COUNT_W-1:0] r_count;
    t_out_item         r_out;
    logic              r_out_valid;
    logic [FILL_W-1:0] w_deep;
    t_status           w_status;

    // clamped modulus
    always_comb begin
        if (r_table_size == '0) begin
            w_mod = RW'(1);
        end else if (32'(r_table_size) > NUM_BUCKETS) begin
            w_mod = RW'(NUM_BUCKETS);
        end else begin
            w_mod = RW'(r_table_size);
        end
    end

    assign w_rem_sh = {r_rem[RW-1:0], r_req.key[5'd31 - r_bitcnt[4:0]]};

    function automatic logic [SW-1:0] slot(input logic [BW-1:0] b, input logic [FW-1:0] w);
        slot = SW'(b) * SW'(WAYS) + SW'(w);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_MOD;
            S_MOD:  if (r_bitcnt == 6'd31) n_state = S_FILL;
            S_FILL: n_state = S_RD;
            S_RD: begin
                if (r_way >= r_fill) n_state = S_UPD;
                else n_state = S_CMP;
            end
            S_CMP: begin
                if (r_rd_key == r_req.key) begin
                    if (t_req'(r_req.req_type) == REQ_DELETE) n_state = S_SHRD;
                    else n_state = S_UPD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_SHRD: begin
                if (r_way >= r_fill) n_state = S_UPD;
                else n_state = S_SHWR;
            end
            S_SHWR: n_state = S_SHRD;
            S_UPD:  n_state = S_DONE;
            S_DONE: if (!r_out_valid) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer: memory port controls
    always_comb begin
        mem_we    = 1'b0;
        key_we    = 1'b0;
        mem_waddr = slot(r_bucket, r_way);
        mem_raddr = slot(r_bucket, r_way);
        mem_wkey  = r_req.key;
        mem_wval  = r_req.value;
        unique case (r_state)
            S_SHWR: begin
                mem_we    = 1'b1;
                key_we    = 1'b1;
                mem_waddr = slot(r_bucket, r_way - FW'(1));
                mem_wkey  = r_rd_key;
                mem_wval  = r_rd_val;
            end
            S_UPD: begin
                if (t_req'(r_req.req_type) == REQ_ADD) begin
                    if (r_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = slot(r_bucket, r_hit);
                    end else if (r_fill < FW'(WAYS)) begin
                        mem_we    = 1'b1;
                        key_we    = 1'b1;
                        mem_waddr = slot(r_bucket, r_fill);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            val_mem[mem_waddr] <= mem_wval;
            if (key_we) begin
                key_mem[mem_waddr] <= mem_wkey;
            end
        end
        r_rd_key <= key_mem[mem_raddr];
        r_rd_val <= val_mem[mem_raddr];
    end

    // deepest level with any bucket
    always_comb begin
        w_deep = '0;
        for (int l = 0; l < WAYS; l++) begin
            if (r_level[l] != '0) w_deep = FILL_W'(l + 1);
        end
    end

    always_comb begin
        w_status = ST_QUERY;
        unique case (t_req'(r_req.req_type))
            REQ_ADD: begin
                if (r_found) w_status = ST_UPDATED;
                else if (r_fill >= FW'(WAYS)) w_status = ST_FULL;
                else w_status = ST_INSERTED;
            end
            REQ_DELETE: w_status = r_found ? ST_DELETED : ST_NOT_FOUND;
            default: w_status = ST_QUERY;
        endcase
    end

    logic w_ins, w_del;
    assign w_ins = (r_state == S_UPD) && (t_req'(r_req.req_type) == REQ_ADD) && !r_found
                   && (r_fill < FW'(WAYS));
    assign w_del = (r_state == S_UPD) && (t_req'(r_req.req_type) == REQ_DELETE) && r_found;

    // fill store: reset clears bucket fills through a valid bit per bucket
    logic [NUM_BUCKETS-1:0] r_bvalid;
    always_ff @(posedge i_clk) begin
        if (w_ins) fill_mem[r_bucket] <= r_fill + FW'(1);
        else if (w_del) fill_mem[r_bucket] <= r_fill - FW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= SIZE_W'(NUM_BUCKETS);
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_bvalid     <= '0;
            for (int l = 0; l < WAYS; l++) r_level[l] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_table_size <= i_cfg_wdata;
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            if (w_ins || w_del) r_bvalid[r_bucket] <= 1'b1;
            if (w_ins) begin
                r_count <= r_count + COUNT_W'(1);
                if (r_fill != '0) begin
                    r_level[WW'(r_fill - FW'(1))] <= r_level[WW'(r_fill - FW'(1))] - LCW'(1);
                end
                r_level[WW'(r_fill)] <= r_level[WW'(r_fill)] + LCW'(1);
            end
            if (w_del) begin
                r_count <= r_count - COUNT_W'(1);
                r_level[WW'(r_fill - FW'(1))] <= r_level[WW'(r_fill - FW'(1))] - LCW'(1);
                if (r_fill > FW'(1)) begin
                    r_level[WW'(r_fill - FW'(2))] <= r_level[WW'(r_fill - FW'(2))] + LCW'(1);
                end
            end
            if (r_state == S_DONE && !r_out_valid) r_out_valid <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_req    <= i_in_data;
                r_rem    <= '0;
                r_bitcnt <= '0;
                r_mod    <= w_mod;
                r_found  <= 1'b0;
                r_hit    <= '0;
                r_way    <= '0;
            end
            S_MOD: begin
                // one restoring step per cycle
                if (w_rem_sh >= {1'b0, r_mod}) r_rem <= w_rem_sh - {1'b0, r_mod};
                else r_rem <= w_rem_sh;
                r_bitcnt <= r_bitcnt + 6'd1;
            end
            S_FILL: begin
                r_bucket <= BW'(r_rem);
                r_fill   <= r_bvalid[BW'(r_rem)] ? fill_mem[BW'(r_rem)] : '0;
            end
            S_RD: ;
            S_CMP: begin
                if (r_rd_key == r_req.key) begin
                    r_found <= 1'b1;
                    r_hit   <= r_way;
                end
                r_way <= r_way + FW'(1);
            end
            S_SHRD: ;
            S_SHWR: r_way <= r_way + FW'(1);
            S_UPD: ;
            S_DONE: begin
                // load only once the previous result has left
                if (!r_out_valid) begin
                    r_out.status     <= w_status;
                    r_out.live_count <= r_count;
                    r_out.max_fill   <= w_deep;
                end
            end
            default: ;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input accepted while busy");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_fill <= FW'(WAYS)))
        else $error("bucket fill above ways");
    a_mod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (r_rem < {1'b0, r_mod}))
        else $error("remainder out of range");

endmodule
